// ----- hdl/rgb_layer_blend_unit_assert.svh -----
// Assertion macros shared by the blend unit's checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef RGB_LAYER_BLEND_UNIT_ASSERT_SVH
`define RGB_LAYER_BLEND_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RLB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_layer_blend_unit: assertion failed");

// next-cycle implication, disabled in reset
`define RLB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb_layer_blend_unit: assertion failed");

`endif

// ----- hdl/rlb_pkg.sv -----
// Shared types and constants of the RGB layer blend unit.
// Used by rlb_channel and rgb_layer_blend_unit; depends on nothing.
package rlb_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned GAIN_W  = 12;
    localparam int unsigned PROD_W  = PIX_W + GAIN_W;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    // register map (index = paddr[3:2])
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_RGAIN  = 2'd2;
    localparam logic [1:0] REG_BGAIN  = 2'd3;

    // reset values
    localparam logic [7:0]  RST_OFFSET = 8'd200;
    localparam logic [11:0] RST_GAIN   = 12'd256;

    // blend modes as programmed
    typedef enum logic [2:0] {
        MODE_MULTIPLY = 3'd0,
        MODE_SUBTRACT = 3'd1,
        MODE_SCREEN   = 3'd2,
        MODE_OVERLAY  = 3'd3,
        MODE_OFFSET   = 3'd4,
        MODE_SCALE    = 3'd5
    } blend_mode_t;

    // per-channel operation
    typedef enum logic [2:0] {
        OP_MUL,
        OP_SUB,
        OP_SCREEN,
        OP_OVERLAY,
        OP_ADDSAT,
        OP_SCALE,
        OP_PASS
    } ch_op_t;

    // how the last stage forms the result
    typedef enum logic [1:0] {
        FIN_ROUND,
        FIN_ROUND_INV,
        FIN_SCALE,
        FIN_DIRECT
    } fin_t;

    // stage load enables, one per pipeline stage
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } rlb_adv_t;

endpackage

// ----- hdl/rgb_layer_blend_unit.sv -----
// Throughput: one pixel pair per cycle; the four-stage channel pipeline
// advances on every cycle in which its output stage is empty or taken.
// Reset (rst_n low, asynchronous): pipeline emptied, blend_mode = multiply,
// green_offset = 200, red_gain = blue_gain = 1.0 (256 in Q4.8).
module rgb_layer_blend_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // top_red, top_green, top_blue,
                                  // bottom_red, bottom_green, bottom_blue
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // out_red, out_green, out_blue
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rlb_pkg::*;

    logic [2:0]  blend_mode_reg;
    logic [7:0]  green_offset_reg;
    logic [11:0] red_gain_reg;
    logic [11:0] blue_gain_reg;
    logic [1:0]  reg_idx;
    logic        cfg_wr;

    logic [4:1]  valid_reg;
    logic [4:1]  stage_rdy;
    rlb_adv_t    adv;

    ch_op_t      op_red, op_green, op_blue;
    logic [7:0]  res_red, res_green, res_blue;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg   <= MODE_MULTIPLY;
            green_offset_reg <= RST_OFFSET;
            red_gain_reg     <= RST_GAIN;
            blue_gain_reg    <= RST_GAIN;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_MODE:   blend_mode_reg   <= pwdata[2:0];
                REG_OFFSET: green_offset_reg <= pwdata[7:0];
                REG_RGAIN:  red_gain_reg     <= pwdata[11:0];
                REG_BGAIN:  blue_gain_reg    <= pwdata[11:0];
                default:    ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            REG_MODE:   prdata = 32'(blend_mode_reg);
            REG_OFFSET: prdata = 32'(green_offset_reg);
            REG_RGAIN:  prdata = 32'(red_gain_reg);
            REG_BGAIN:  prdata = 32'(blue_gain_reg);
            default:    prdata = '0;
        endcase
    end

    // pipeline control: a stage loads when it is empty or its beat moves on
    assign stage_rdy[4] = ~valid_reg[4] | m_tready;
    assign stage_rdy[3] = ~valid_reg[3] | stage_rdy[4];
    assign stage_rdy[2] = ~valid_reg[2] | stage_rdy[3];
    assign stage_rdy[1] = ~valid_reg[1] | stage_rdy[2];

    assign adv.s1 = stage_rdy[1];
    assign adv.s2 = stage_rdy[2];
    assign adv.s3 = stage_rdy[3];
    assign adv.s4 = stage_rdy[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_rdy[1]) valid_reg[1] <= s_tvalid;
            if (stage_rdy[2]) valid_reg[2] <= valid_reg[1];
            if (stage_rdy[3]) valid_reg[3] <= valid_reg[2];
            if (stage_rdy[4]) valid_reg[4] <= valid_reg[3];
        end
    end

    assign s_tready = stage_rdy[1];
    assign m_tvalid = valid_reg[4];

    // per-channel operation from the blend mode
    always_comb
    begin
        case (blend_mode_reg)
            MODE_MULTIPLY:
            begin
                op_red = OP_MUL;     op_green = OP_MUL;     op_blue = OP_MUL;
            end
            MODE_SUBTRACT:
            begin
                op_red = OP_SUB;     op_green = OP_SUB;     op_blue = OP_SUB;
            end
            MODE_SCREEN:
            begin
                op_red = OP_SCREEN;  op_green = OP_SCREEN;  op_blue = OP_SCREEN;
            end
            MODE_OVERLAY:
            begin
                op_red = OP_OVERLAY; op_green = OP_OVERLAY; op_blue = OP_OVERLAY;
            end
            MODE_OFFSET:
            begin
                op_red = OP_PASS;    op_green = OP_ADDSAT;  op_blue = OP_PASS;
            end
            MODE_SCALE:
            begin
                op_red = OP_SCALE;   op_green = OP_PASS;    op_blue = OP_SCALE;
            end
            default:
            begin
                op_red = OP_PASS;    op_green = OP_PASS;    op_blue = OP_PASS;
            end
        endcase
    end

    // channel datapaths
    rlb_channel u_red (
        .clk    (clk),
        .adv    (adv),
        .op     (op_red),
        .a      (s_tdata[7:0]),
        .b      (s_tdata[31:24]),
        .gain   (red_gain_reg),
        .offset (green_offset_reg),
        .result (res_red)
    );

    rlb_channel u_green (
        .clk    (clk),
        .adv    (adv),
        .op     (op_green),
        .a      (s_tdata[15:8]),
        .b      (s_tdata[39:32]),
        .gain   (red_gain_reg),
        .offset (green_offset_reg),
        .result (res_green)
    );

    rlb_channel u_blue (
        .clk    (clk),
        .adv    (adv),
        .op     (op_blue),
        .a      (s_tdata[23:16]),
        .b      (s_tdata[47:40]),
        .gain   (blue_gain_reg),
        .offset (green_offset_reg),
        .result (res_blue)
    );

    assign m_tdata = {res_blue, res_green, res_red};

endmodule

// ----- hdl/rlb_channel.sv -----
// Four-stage datapath for one color channel of the blend unit.
// Depends on rlb_pkg; stage enables come from the top level.
module rlb_channel (
    input  logic              clk,
    input  rlb_pkg::rlb_adv_t adv,
    input  rlb_pkg::ch_op_t   op,
    input  logic [7:0]        a,
    input  logic [7:0]        b,
    input  logic [11:0]       gain,
    input  logic [7:0]        offset,
    output logic [7:0]        result
);
    import rlb_pkg::*;

    // stage 1 registers
    logic [7:0]  x_reg, x_next;
    logic [11:0] y_reg, y_next;
    logic        dbl1_reg, dbl1_next;
    fin_t        fin1_reg, fin1_next;
    logic [7:0]  dir1_reg, dir1_next;
    logic [8:0]  sum9;

    // stage 2 registers
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic        dbl2_reg;
    fin_t        fin2_reg;
    logic [7:0]  dir2_reg;

    // stage 3 registers
    logic [17:0] m_reg, m_next;
    logic [8:0]  est_reg, est_next;
    fin_t        fin3_reg;
    logic [7:0]  dir3_reg, dir3_next;
    logic [25:0] est_wide;
    logic [11:0] scaled;

    // stage 4
    logic [17:0] est255;
    logic [17:0] rem;
    logic [8:0]  q;
    logic [7:0]  result_reg, result_next;

    // stage 1: pick multiplier operands or the direct result
    always_comb
    begin
        sum9      = {1'b0, b} + {1'b0, offset};
        x_next    = a;
        y_next    = {4'b0, b};
        dbl1_next = 1'b0;
        fin1_next = FIN_DIRECT;
        dir1_next = b;
        case (op)
            OP_MUL:
            begin
                fin1_next = FIN_ROUND;
            end
            OP_SUB:
            begin
                dir1_next = (b >= a) ? (b - a) : 8'd0;
            end
            OP_SCREEN:
            begin
                x_next    = ~a;
                y_next    = {4'b0, ~b};
                fin1_next = FIN_ROUND_INV;
            end
            OP_OVERLAY:
            begin
                dbl1_next = 1'b1;
                if (b[7])
                begin
                    x_next    = ~a;
                    y_next    = {4'b0, ~b};
                    fin1_next = FIN_ROUND_INV;
                end
                else
                begin
                    fin1_next = FIN_ROUND;
                end
            end
            OP_ADDSAT:
            begin
                dir1_next = sum9[8] ? 8'hFF : sum9[7:0];
            end
            OP_SCALE:
            begin
                x_next    = b;
                y_next    = gain;
                fin1_next = FIN_SCALE;
            end
            default:
            begin
                dir1_next = b;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            dbl1_reg <= dbl1_next;
            fin1_reg <= fin1_next;
            dir1_reg <= dir1_next;
        end
    end

    // stage 2: the one multiply
    assign prod_next = PROD_W'(x_reg) * PROD_W'(y_reg);

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            prod_reg <= prod_next;
            dbl2_reg <= dbl1_reg;
            fin2_reg <= fin1_reg;
            dir2_reg <= dir1_reg;
        end
    end

    // stage 3: add rounding bias, estimate m/255 as m*257>>16, saturate scale
    always_comb
    begin
        m_next   = (dbl2_reg ? {prod_reg[16:0], 1'b0} : {1'b0, prod_reg[16:0]}) + 18'd127;
        est_wide = {m_next, 8'b0} + {8'b0, m_next};
        est_next = est_wide[24:16];
        scaled   = prod_reg[19:8];
        if (fin2_reg == FIN_SCALE)
            dir3_next = (|scaled[11:8]) ? 8'hFF : scaled[7:0];
        else
            dir3_next = dir2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            m_reg    <= m_next;
            est_reg  <= est_next;
            fin3_reg <= fin2_reg;
            dir3_reg <= dir3_next;
        end
    end

    // stage 4: the estimate is low by at most one; fix it and finish
    always_comb
    begin
        est255 = {1'b0, est_reg, 8'b0} - {9'b0, est_reg};
        rem    = m_reg - est255;
        q      = (rem >= 18'd255) ? (est_reg + 9'd1) : est_reg;
        case (fin3_reg)
            FIN_ROUND:     result_next = q[7:0];
            FIN_ROUND_INV: result_next = ~q[7:0];
            default:       result_next = dir3_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- hdl/rlb_checker.sv -----
// Port-level checks for rgb_layer_blend_unit, bound to the top level.
// Depends on rgb_layer_blend_unit_assert.svh for the assertion macros.
`include "rgb_layer_blend_unit_assert.svh"

module rlb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a stalled output beat stays and holds its data
    `RLB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `RLB_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))

    // with no back-pressure at the output the input never stalls
    `RLB_ASSERT_IMP(a_no_stall, m_tready || !m_tvalid, s_tready)

    // a beat accepted into a free-running pipe reaches the output once it has passed all pipeline stages
    `RLB_ASSERT_IMP(a_latency,
        $past(s_tvalid && s_tready && rst_n, 4) && $past(rst_n, 3) &&
        $past(rst_n, 2) && $past(rst_n, 1) && $past(m_tready, 3) &&
        $past(m_tready, 2) && $past(m_tready, 1),
        m_tvalid)

endmodule

bind rgb_layer_blend_unit rlb_checker u_rlb_checker (.*);

// ----- tb/sv/rgb_layer_blend_unit_tb.sv -----
// Self-checking testbench for rgb_layer_blend_unit: streams pixel pairs through the
// blend pipeline under every blend mode and a range of register settings, predicts each pixel.
// Depends on rlb_pkg and the rgb_layer_blend_unit RTL.
module rgb_layer_blend_unit_tb;
    import rlb_pkg::*;

    // codes the block treats as pass-through
    localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_ITEMS   = 42;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        rgb_t bottom;
        rgb_t top;
    } layer_pair_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // top_red, top_green, top_blue, bottom_red, bottom_green, bottom_blue
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;        // out_red, out_green, out_blue
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the block's registers
    logic [2:0]  cfg_mode = MODE_MULTIPLY;
    logic [7:0]  cfg_offset = RST_OFFSET;
    logic [11:0] cfg_red_gain = RST_GAIN;
    logic [11:0] cfg_blue_gain = RST_GAIN;

    layer_pair_t pending_pairs[$];
    rgb_t        expected_pixels[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          src_idle_pct = 29;
    int          sink_idle_pct = 29;
    int          hold_asked = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    string       chan_names[3] = '{"out_red", "out_green", "out_blue"};

    rgb_layer_blend_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------- prediction

    // round(n/255); n/255 never lands on a half since 255 is odd, so no ties
    function automatic int unsigned round_div255(int unsigned n);
        return (2 * n + 255) / 510;
    endfunction

    function automatic logic [7:0] clip255(int unsigned v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [7:0] blend_channel(logic [7:0] top_v, logic [7:0] bot_v);
        int unsigned a;
        int unsigned b;
        a = top_v;
        b = bot_v;
        case (cfg_mode)
            MODE_MULTIPLY: return round_div255(a * b);
            MODE_SUBTRACT: return (b >= a) ? b - a : 0;
            MODE_SCREEN:   return 255 - round_div255((255 - a) * (255 - b));
            MODE_OVERLAY:
                if (b < 128)
                    return round_div255(2 * a * b);
                else
                    return 255 - round_div255(2 * (255 - a) * (255 - b));
            default:       return bot_v;
        endcase
    endfunction

    function automatic rgb_t blend_pixel(layer_pair_t p);
        rgb_t px;
        px = p.bottom;
        if (cfg_mode == MODE_OFFSET) begin
            px.green = clip255(int'(p.bottom.green) + int'(cfg_offset));
        end
        else if (cfg_mode == MODE_SCALE) begin
            px.red  = clip255((int'(p.bottom.red) * int'(cfg_red_gain)) >> 8);
            px.blue = clip255((int'(p.bottom.blue) * int'(cfg_blue_gain)) >> 8);
        end
        else begin
            px.red   = blend_channel(p.top.red, p.bottom.red);
            px.green = blend_channel(p.top.green, p.bottom.green);
            px.blue  = blend_channel(p.top.blue, p.bottom.blue);
        end
        return px;
    endfunction

    // ---------------------------------------------------------------- stream driver

    // next beat goes out once the current one is taken; prediction at acceptance
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else begin
            if (s_tvalid && s_tready)
                expected_pixels.push_back(blend_pixel(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_pairs.pop_front();
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sink backpressure

    always @(posedge clk) begin
        if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else begin
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // ---------------------------------------------------------------- result monitor

    always @(posedge clk) begin
        rgb_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected output beat, expected none, got %h", $time, m_tdata);
            end
            else begin
                want = expected_pixels.pop_front();
                for (int k = 0; k < 3; k++) begin
                    if (m_tdata[8*k +: 8] !== want[8*k +: 8]) begin
                        mismatches++;
                        $display("%0t: %s mismatch, expected %0d, got %0d", $time,
                                 chan_names[k], want[8*k +: 8], m_tdata[8*k +: 8]);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------- register access

    // write with junk in the unused upper bits, then read back
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] wdata;
        mask = (idx == REG_MODE) ? 32'h7 : (idx == REG_OFFSET) ? 32'hFF : 32'hFFF;
        wdata = ($urandom() & ~mask) | (value & mask);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:   cfg_mode      = wdata[2:0];
            REG_OFFSET: cfg_offset    = wdata[7:0];
            REG_RGAIN:  cfg_red_gain  = wdata[11:0];
            default:    cfg_blue_gain = wdata[11:0];
        endcase
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== (wdata & mask)) begin
            mismatches++;
            $display("%0t: register %0d readback, expected %h, got %h", $time, idx,
                     wdata & mask, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---------------------------------------------------------------- stimulus

    // biased toward the byte extremes and the overlay threshold
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        if ($urandom_range(0, 4) == 0)
            return corners[$urandom_range(0, 5)];
        return $urandom_range(0, 255);
    endfunction

    function automatic layer_pair_t pick_pair();
        layer_pair_t p;
        p.top    = {pick_byte(), pick_byte(), pick_byte()};
        p.bottom = {pick_byte(), pick_byte(), pick_byte()};
        return p;
    endfunction

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || s_tvalid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        layer_pair_t corner_pairs[3];
        logic [2:0]  mode_plan[RAND_PHASES];
        logic [31:0] offset_val;
        logic [31:0] rgain_val;
        logic [31:0] bgain_val;

        // channel combos: zero/full/threshold, both orders of top vs bottom
        corner_pairs[0] = '{bottom: '{blue: 8'd128, green: 8'd255, red: 8'd0},
                           top:    '{blue: 8'd127, green: 8'd255, red: 8'd0}};
        corner_pairs[1] = '{bottom: '{blue: 8'd127, green: 8'd255, red: 8'd0},
                           top:    '{blue: 8'd128, green: 8'd0, red: 8'd255}};
        corner_pairs[2] = '{bottom: '{blue: 8'd255, green: 8'd0, red: 8'd255},
                           top:    '{blue: 8'd0, green: 8'd255, red: 8'd255}};
        mode_plan = '{MODE_MULTIPLY, MODE_SUBTRACT, MODE_SCREEN, MODE_OVERLAY,
                      MODE_OFFSET, MODE_SCALE, MODE_OFFSET, MODE_SCALE,
                      MODE_UNDEF_LO, MODE_UNDEF_HI, MODE_OVERLAY, MODE_SCALE};
        mode_plan[RAND_PHASES-1] = $urandom_range(0, 7);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every mode on corner pixels; offset and gains at reset values
        for (int m = 0; m < 8; m++) begin
            if (m != 0)
                write_reg(REG_MODE, m);
            foreach (corner_pairs[i])
                pending_pairs.push_back(corner_pairs[i]);
            wait_drained();
        end

        // random phases, register extremes rotate through the phases
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 3)
                0:       offset_val = 0;
                1:       offset_val = 255;
                default: offset_val = $urandom_range(0, 255);
            endcase
            case (ph % 4)
                0:       begin rgain_val = 0;    bgain_val = 4095; end
                1:       begin rgain_val = 4095; bgain_val = 0;    end
                2:       begin rgain_val = 256;  bgain_val = $urandom_range(0, 4095); end
                default: begin rgain_val = $urandom_range(0, 4095);
                               bgain_val = $urandom_range(0, 4095); end
            endcase
            write_reg(REG_MODE, mode_plan[ph]);
            write_reg(REG_OFFSET, offset_val);
            write_reg(REG_RGAIN, rgain_val);
            write_reg(REG_BGAIN, bgain_val);

            src_idle_pct  = (ph == 2) ? 0 : 29;
            sink_idle_pct = (ph == 2) ? 0 : 29;

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pending_pairs.push_back(pick_pair());
                // sender stops mid-phase until the pipeline is empty
                if (ph == 9 && i == PHASE_ITEMS / 2)
                    wait_drained();
            end
            // long sink stall while the sender keeps offering
            if (ph == 5)
                hold_asked = hold_asked + 1;
            wait_drained();
        end

        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
